>>> rtl/gsc_pkg.sv
// Shared types and constants for the graphics packet census parser.
package gsc_pkg;

  // Counter bank layout
  localparam int NUM_CNT   = 15;
  localparam int CNT_IDX_W = 4;
  localparam logic [CNT_IDX_W-1:0] LAST_CNT_ID = CNT_IDX_W'(NUM_CNT - 1);

  localparam int CNT_BYTES  = 0;
  localparam int CNT_TAGS   = 1;
  localparam int CNT_IMAGE  = 2;
  localparam int CNT_AD     = 3;
  localparam int CNT_BITBLT = 4;
  localparam int CNT_TRXDIR = 5;
  localparam int CNT_TEX0   = 6;
  localparam int CNT_VERTS  = 7;
  localparam int NUM_PRIM   = 8;

  // Packets shorter than this produce no report
  localparam int MIN_REPORT_BYTES = 16;

  // Bytes in one full word
  localparam logic [3:0] WORD_BYTES = 4'd8;

  // Primitive type after reset: unknown
  localparam logic [2:0] PRIM_UNKNOWN = 3'd7;

  // Tag flag field values
  localparam logic [1:0] FLG_PACKED  = 2'd0;
  localparam logic [1:0] FLG_REGLIST = 2'd1;

  // Register descriptors
  localparam logic [3:0] DESC_PRIM = 4'h0;
  localparam logic [3:0] DESC_XYZ2 = 4'h4;
  localparam logic [3:0] DESC_XYZF2 = 4'h5;
  localparam logic [3:0] DESC_AD   = 4'hE;

  // A+D target addresses
  localparam logic [7:0] ADDR_PRIM   = 8'h00;
  localparam logic [7:0] ADDR_XYZ2   = 8'h04;
  localparam logic [7:0] ADDR_XYZF2  = 8'h05;
  localparam logic [7:0] ADDR_TEX0_1 = 8'h06;
  localparam logic [7:0] ADDR_TEX0_2 = 8'h07;
  localparam logic [7:0] ADDR_BITBLT = 8'h50;
  localparam logic [7:0] ADDR_TRXDIR = 8'h53;

  // Walker phase, one-hot
  typedef enum logic [6:0] {
    PH_TAG_LO    = 7'b0000001,
    PH_TAG_HI    = 7'b0000010,
    PH_IMAGE     = 7'b0000100,
    PH_REGLIST   = 7'b0001000,
    PH_PAD       = 7'b0010000,
    PH_PACKED_LO = 7'b0100000,
    PH_PACKED_HI = 7'b1000000
  } phase_t;

  // Events decoded from one word, consumed by the counter bank
  typedef struct packed {
    logic       tag;
    logic       ad;
    logic       bitblt;
    logic       trxdir;
    logic       tex0;
    logic       kick;
    logic [2:0] kick_prim;
    logic [3:0] image_take;
  } evt_t;

endpackage

>>> rtl/gif_stream_census_parser.sv
// Top level of the graphics packet census parser.
// A packet streams in as 64-bit little-endian words, one per accepted word, the
// last one flagged by last_word. Each word is parsed straight from the input
// register: tags are decoded, image/disable payloads are skipped and their
// bytes counted, REGLIST and PACKED registers are stepped through, and vertex
// kicks are binned by the current primitive type, which carries over from packet
// to packet. Sustained rate is one word per clock, but for the stall below. At
// the last word of a packet of 16 bytes or more, fifteen saturating counters
// (COUNTER_BITS wide, shown as their low 32 bits) are copied to a report
// buffer and leave on the result channel, one per handshake, counter_id 0 to
// 14, last_result on the final one. Parsing of the next packet overlaps with
// that drain; only a packet's last word waits, in the input register, while
// a previous report is still in the buffer, so a drain can hold off a packet.
module gif_stream_census_parser import gsc_pkg::*; #(
  parameter int COUNTER_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 word_valid,
  output logic                 word_ready,
  input  logic [1:0]           path,
  input  logic [31:0]          program_id,
  input  logic [63:0]          word,
  input  logic [3:0]           bytes_valid,
  input  logic                 last_word,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [1:0]           class_path,
  output logic [31:0]          class_program,
  output logic [CNT_IDX_W-1:0] counter_id,
  output logic [31:0]          count,
  output logic                 last_result
);

  // input register
  logic        in_full;
  logic [1:0]  r_path;
  logic [31:0] r_program;
  logic [63:0] r_word;
  logic [3:0]  r_bytes;
  logic        r_last;

  logic        go;
  logic [3:0]  bytes_c;
  logic        full_w;

  evt_t                                 evt;
  logic [NUM_CNT-1:0][COUNTER_BITS-1:0] snap;
  logic [1:0]                           snap_path;
  logic [31:0]                          snap_program;
  logic                                 emit;

  // a last word needs the report buffer free
  assign go         = in_full && (!r_last || !result_valid);
  assign word_ready = !in_full || go;

  // out-of-range byte counts clamp to a full word
  assign bytes_c = (r_bytes > WORD_BYTES) ? WORD_BYTES : r_bytes;
  // a short last word is too short to finish a tag or register
  assign full_w  = (bytes_c == WORD_BYTES) || !r_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (word_ready) begin
      in_full <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      r_path    <= path;
      r_program <= program_id;
      r_word    <= word;
      r_bytes   <= bytes_valid;
      r_last    <= last_word;
    end
  end

  gsc_walker u_walker (
    .clk  (clk),
    .rst  (rst),
    .fire (go),
    .word (r_word),
    .bytes(bytes_c),
    .full (full_w),
    .last (r_last),
    .evt  (evt)
  );

  gsc_counters #(.CW(COUNTER_BITS)) u_counters (
    .clk         (clk),
    .rst         (rst),
    .fire        (go),
    .bytes       (bytes_c),
    .last        (r_last),
    .path        (r_path),
    .program_id  (r_program),
    .evt         (evt),
    .snap        (snap),
    .snap_path   (snap_path),
    .snap_program(snap_program),
    .emit        (emit)
  );

  gsc_report #(.CW(COUNTER_BITS)) u_report (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .snap         (snap),
    .snap_path    (snap_path),
    .snap_program (snap_program),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .class_path   (class_path),
    .class_program(class_program),
    .counter_id   (counter_id),
    .count        (count),
    .last_result  (last_result)
  );

`ifndef SYNTHESIS
  // a report is never loaded over one still draining
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> !result_valid)
    else $error("report loaded while buffer busy");

  // the drain ends right after the final counter is taken
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && last_result) |=> !result_valid)
    else $error("report still valid after final counter");

  // input stalls only on a held last word behind a busy report
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !word_ready |-> (in_full && r_last && result_valid))
    else $error("input stalled without cause");

  // counters leave in order, with no gap
  a_id_step: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !last_result) |=>
      (result_valid && counter_id == $past(counter_id) + 4'd1))
    else $error("counter id sequence broken");
`endif

endmodule

>>> rtl/gsc_walker.sv
// Tag walker: phase tracking, register slot stepping and event decode per word.
module gsc_walker import gsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [63:0] word,
  input  logic [3:0]  bytes,
  input  logic        full,
  input  logic        last,
  output evt_t        evt
);

  phase_t      phase, phase_next;
  logic [2:0]  cur_prim, cur_prim_next;
  logic [14:0] loop_rem, loop_rem_next;
  logic [4:0]  reg_count, reg_count_next;
  logic [3:0]  reg_index, reg_index_next;
  logic [63:0] desc, desc_next;
  logic [63:0] held, held_next;
  logic [19:0] img_left, img_left_next;
  logic        pad, pad_next;

  logic [3:0]  d;
  logic [4:0]  idx_inc;
  logic        wrap;
  logic [14:0] loop_adv;
  logic        done;
  logic [14:0] nloop;
  logic [1:0]  flg;
  logic [4:0]  nreg;
  logic [7:0]  ad_addr;

  always_comb begin
    d        = desc[{reg_index, 2'b00} +: 4];
    idx_inc  = {1'b0, reg_index} + 5'd1;
    wrap     = idx_inc >= reg_count;
    loop_adv = (wrap && loop_rem != 15'd0) ? loop_rem - 15'd1 : loop_rem;
    done     = loop_adv == 15'd0;
    nloop    = held[14:0];
    flg      = held[59:58];
    nreg     = (held[63:60] == 4'd0) ? 5'd16 : {1'b0, held[63:60]};
    ad_addr  = word[7:0];

    phase_next     = phase;
    cur_prim_next  = cur_prim;
    loop_rem_next  = loop_rem;
    reg_count_next = reg_count;
    reg_index_next = reg_index;
    desc_next      = desc;
    held_next      = held;
    img_left_next  = img_left;
    pad_next       = pad;
    evt            = '0;
    evt.kick_prim  = cur_prim;

    case (phase)
      PH_TAG_LO: begin
        held_next  = word;
        phase_next = PH_TAG_HI;
      end
      PH_TAG_HI: begin
        if (full) begin
          evt.tag = 1'b1;
          if (held[46]) cur_prim_next = held[49:47];
          desc_next      = word;
          reg_count_next = nreg;
          reg_index_next = 4'd0;
          loop_rem_next  = nloop;
          phase_next     = PH_TAG_LO;
          if (flg[1]) begin
            img_left_next = {1'b0, nloop, 4'b0000};
            if (nloop != 15'd0) phase_next = PH_IMAGE;
          end else if (flg == FLG_REGLIST) begin
            pad_next = nloop[0] & nreg[0];
            if (nloop != 15'd0) phase_next = PH_REGLIST;
          end else begin
            if (nloop != 15'd0) phase_next = PH_PACKED_LO;
          end
        end
      end
      PH_IMAGE: begin
        evt.image_take = (img_left < 20'(bytes)) ? img_left[3:0] : bytes;
        img_left_next  = (img_left > 20'd8) ? img_left - 20'd8 : 20'd0;
        if (img_left <= 20'd8) phase_next = PH_TAG_LO;
      end
      PH_REGLIST: begin
        if (full) begin
          if (d == DESC_XYZ2 || d == DESC_XYZF2) evt.kick = 1'b1;
          else if (d == DESC_PRIM) cur_prim_next = word[2:0];
          reg_index_next = wrap ? 4'd0 : idx_inc[3:0];
          loop_rem_next  = loop_adv;
          if (done) phase_next = pad ? PH_PAD : PH_TAG_LO;
        end
      end
      PH_PAD: begin
        pad_next   = 1'b0;
        phase_next = PH_TAG_LO;
      end
      PH_PACKED_LO: begin
        held_next  = word;
        phase_next = PH_PACKED_HI;
      end
      PH_PACKED_HI: begin
        if (full) begin
          if (d == DESC_XYZ2 || d == DESC_XYZF2) begin
            if (!word[47]) evt.kick = 1'b1;
          end else if (d == DESC_PRIM) begin
            cur_prim_next = held[2:0];
          end else if (d == DESC_AD) begin
            evt.ad = 1'b1;
            if (ad_addr == ADDR_PRIM) cur_prim_next = held[2:0];
            else if (ad_addr == ADDR_XYZ2 || ad_addr == ADDR_XYZF2) evt.kick = 1'b1;
            else if (ad_addr == ADDR_BITBLT) evt.bitblt = 1'b1;
            else if (ad_addr == ADDR_TRXDIR) evt.trxdir = 1'b1;
            else if (ad_addr == ADDR_TEX0_1 || ad_addr == ADDR_TEX0_2) evt.tex0 = 1'b1;
          end
          reg_index_next = wrap ? 4'd0 : idx_inc[3:0];
          loop_rem_next  = loop_adv;
          phase_next     = done ? PH_TAG_LO : PH_PACKED_LO;
        end
      end
      default: begin
        phase_next = PH_TAG_LO;
      end
    endcase

    // end of packet: everything but the primitive type starts over
    if (last) begin
      phase_next     = PH_TAG_LO;
      loop_rem_next  = 15'd0;
      reg_count_next = 5'd0;
      reg_index_next = 4'd0;
      img_left_next  = 20'd0;
      pad_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TAG_LO;
      cur_prim  <= PRIM_UNKNOWN;
      loop_rem  <= 15'd0;
      reg_count <= 5'd0;
      reg_index <= 4'd0;
      img_left  <= 20'd0;
      pad       <= 1'b0;
    end else if (fire) begin
      phase     <= phase_next;
      cur_prim  <= cur_prim_next;
      loop_rem  <= loop_rem_next;
      reg_count <= reg_count_next;
      reg_index <= reg_index_next;
      img_left  <= img_left_next;
      pad       <= pad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      desc <= desc_next;
      held <= held_next;
    end
  end

endmodule

>>> rtl/gsc_counters.sv
// Per-packet saturating counter bank and packet class capture.
module gsc_counters import gsc_pkg::*; #(
  parameter int CW = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic [3:0]                 bytes,
  input  logic                       last,
  input  logic [1:0]                 path,
  input  logic [31:0]                program_id,
  input  evt_t                       evt,
  output logic [NUM_CNT-1:0][CW-1:0] snap,
  output logic [1:0]                 snap_path,
  output logic [31:0]                snap_program,
  output logic                       emit
);

  logic [NUM_CNT-1:0][CW-1:0] cnt;
  logic [NUM_CNT-1:0][3:0]    inc;
  logic [NUM_CNT-1:0][CW:0]   sum;
  logic                       started;
  logic [1:0]                 cls_path;
  logic [31:0]                cls_program;

  always_comb begin
    inc             = '0;
    inc[CNT_BYTES]  = bytes;
    inc[CNT_TAGS]   = {3'd0, evt.tag};
    inc[CNT_IMAGE]  = evt.image_take;
    inc[CNT_AD]     = {3'd0, evt.ad};
    inc[CNT_BITBLT] = {3'd0, evt.bitblt};
    inc[CNT_TRXDIR] = {3'd0, evt.trxdir};
    inc[CNT_TEX0]   = {3'd0, evt.tex0};
    for (int p = 0; p < NUM_PRIM; p++) begin
      inc[CNT_VERTS + p] = {3'd0, evt.kick && (evt.kick_prim == 3'(p))};
    end
    // saturating add: carry out pins the counter at all ones
    for (int k = 0; k < NUM_CNT; k++) begin
      sum[k]  = {1'b0, cnt[k]} + (CW + 1)'(inc[k]);
      snap[k] = sum[k][CW] ? '1 : sum[k][CW-1:0];
    end
  end

  // class comes from the packet's first word
  assign snap_path    = started ? cls_path : path;
  assign snap_program = started ? cls_program :
                        ((path == 2'd1) ? program_id : 32'd0);
  assign emit = fire && last && (snap[CNT_BYTES] >= CW'(MIN_REPORT_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      started <= 1'b0;
    end else if (fire) begin
      if (last) begin
        cnt     <= '0;
        started <= 1'b0;
      end else begin
        cnt     <= snap;
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cls_path    <= snap_path;
      cls_program <= snap_program;
    end
  end

endmodule

>>> rtl/gsc_report.sv
// Report buffer: holds one packet's counters and shifts them out one per handshake.
module gsc_report import gsc_pkg::*; #(
  parameter int CW = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [NUM_CNT-1:0][CW-1:0] snap,
  input  logic [1:0]                 snap_path,
  input  logic [31:0]                snap_program,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [1:0]                 class_path,
  output logic [31:0]                class_program,
  output logic [CNT_IDX_W-1:0]       counter_id,
  output logic [31:0]                count,
  output logic                       last_result
);

  logic [NUM_CNT-1:0][CW-1:0] buf_cnt;
  logic [CNT_IDX_W-1:0]       idx;
  logic                       busy;
  logic                       pop;

  assign pop           = busy && result_ready;
  assign result_valid  = busy;
  assign counter_id    = idx;
  assign count         = 32'(buf_cnt[0]);
  assign last_result   = idx == LAST_CNT_ID;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (pop) begin
      idx <= idx + 1'b1;
      if (idx == LAST_CNT_ID) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_cnt       <= snap;
      class_path    <= snap_path;
      class_program <= snap_program;
    end else if (pop) begin
      for (int k = 0; k < NUM_CNT - 1; k++) begin
        buf_cnt[k] <= buf_cnt[k+1];
      end
    end
  end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the graphics packet census parser.
`timescale 1ns / 100ps

module testbench;
  import gsc_pkg::*;

  localparam int CNT_BITS = 32;
  localparam logic [63:0] CNT_MAX = (CNT_BITS >= 64) ? '1 : ((64'd1 << CNT_BITS) - 64'd1);

  // Tag flag value the package leaves out
  localparam logic [1:0] FLG_IMAGE   = 2'd2;

  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TAIL_CYCLES    = 30;

  // One input word as the driver presents it
  typedef struct packed {
    logic [1:0]  path;
    logic [31:0] prog;
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } gif_word_t;

  // One counter of a packet report
  typedef struct packed {
    logic [1:0]  cpath;
    logic [31:0] cprog;
    logic [3:0]  cid;
    logic [31:0] cval;
    logic        clast;
  } census_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        word_valid = 1'b0;
  logic        word_ready;
  logic [1:0]  path = '0;
  logic [31:0] program_id = '0;
  logic [63:0] word = '0;
  logic [3:0]  bytes_valid = '0;
  logic        last_word = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  class_path;
  logic [31:0] class_program;
  logic [CNT_IDX_W-1:0] counter_id;
  logic [31:0] count;
  logic        last_result;

  gif_stream_census_parser #(.COUNTER_BITS(CNT_BITS)) i_dut (
    .clk(clk), .rst(rst),
    .word_valid(word_valid), .word_ready(word_ready),
    .path(path), .program_id(program_id), .word(word),
    .bytes_valid(bytes_valid), .last_word(last_word),
    .result_valid(result_valid), .result_ready(result_ready),
    .class_path(class_path), .class_program(class_program),
    .counter_id(counter_id), .count(count), .last_result(last_result)
  );

  // Stimulus queues and handshake bookkeeping
  gif_word_t   pending_words[$];
  logic [63:0] pkt_words[$];
  census_t     census_q[$];
  int          words_offered = 0;
  int          words_taken = 0;
  int          words_queued = 0;
  int          fail_cnt = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  int          holdoff_left = 0;

  // Shadow of the walker state
  phase_t      walk_phase;
  logic [2:0]  cur_prim;
  logic [31:0] loops_left;
  int          regs_in_tag;
  int          reg_slot;
  logic [63:0] desc_word;
  logic [63:0] held_lo;
  logic [31:0] image_left;
  logic [63:0] tally [NUM_CNT];
  logic [1:0]  pkt_path;
  logic [31:0] pkt_prog;
  bit          pkt_started;
  bit          pad_due;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Queue tail appends
  function automatic void append_pkt(logic [63:0] w);
    pkt_words.insert(pkt_words.size(), w);
  endfunction

  function automatic void append_item(gif_word_t it);
    pending_words.insert(pending_words.size(), it);
  endfunction

  function automatic void append_census(census_t rec);
    census_q.insert(census_q.size(), rec);
  endfunction

  // ---------------------------------------------------------------------
  // Shadow model of the tag walker
  // ---------------------------------------------------------------------

  // Saturating add into one packet counter
  function automatic void tally_add(int id, logic [63:0] amt);
    logic [63:0] v;
    v = tally[id];
    if (v >= CNT_MAX || amt > CNT_MAX - v) v = CNT_MAX;
    else v = v + amt;
    tally[id] = v;
  endfunction

  function automatic void kick();
    tally_add(CNT_VERTS + int'(cur_prim), 64'd1);
  endfunction

  // Everything but the primitive type is per packet
  function automatic void clear_packet();
    int k;
    walk_phase = PH_TAG_LO;
    loops_left = '0;
    regs_in_tag = 0;
    reg_slot = 0;
    desc_word = '0;
    held_lo = '0;
    image_left = '0;
    for (k = 0; k < NUM_CNT; k++) tally[k] = '0;
    pkt_path = '0;
    pkt_prog = '0;
    pkt_started = 1'b0;
    pad_due = 1'b0;
  endfunction

  function automatic logic [3:0] cur_desc();
    return desc_word[4*reg_slot +: 4];
  endfunction

  // Step to the next register slot; true once all loops are done
  function automatic bit next_slot();
    reg_slot++;
    if (reg_slot >= regs_in_tag) begin
      reg_slot = 0;
      if (loops_left > 0) loops_left--;
    end
    return loops_left == 0;
  endfunction

  function automatic void decode_tag(logic [63:0] lo, logic [63:0] hi);
    logic [1:0] flg;
    int         nreg;
    logic [31:0] nloop;
    nloop = {17'd0, lo[14:0]};
    flg = lo[59:58];
    nreg = (lo[63:60] == 4'd0) ? 16 : int'(lo[63:60]);
    tally_add(CNT_TAGS, 64'd1);
    if (lo[46]) cur_prim = lo[49:47];
    desc_word = hi;
    regs_in_tag = nreg;
    reg_slot = 0;
    loops_left = nloop;
    walk_phase = PH_TAG_LO;
    if (flg >= FLG_IMAGE) begin
      image_left = nloop * 32'd16;
      if (image_left > 0) walk_phase = PH_IMAGE;
    end else if (flg == FLG_REGLIST) begin
      // odd register total in REGLIST mode is padded to a whole qword
      pad_due = nloop[0] && nreg[0];
      if (nloop > 0) walk_phase = PH_REGLIST;
    end else begin
      if (nloop > 0) walk_phase = PH_PACKED_LO;
    end
  endfunction

  function automatic void packed_reg(logic [63:0] qlo, logic [63:0] qhi);
    logic [7:0] addr;
    addr = qhi[7:0];
    case (cur_desc())
      DESC_XYZ2, DESC_XYZF2: if (!qhi[47]) kick();
      DESC_PRIM: cur_prim = qlo[2:0];
      DESC_AD: begin
        tally_add(CNT_AD, 64'd1);
        case (addr)
          ADDR_PRIM: cur_prim = qlo[2:0];
          ADDR_XYZ2, ADDR_XYZF2: kick();
          ADDR_BITBLT: tally_add(CNT_BITBLT, 64'd1);
          ADDR_TRXDIR: tally_add(CNT_TRXDIR, 64'd1);
          ADDR_TEX0_1, ADDR_TEX0_2: tally_add(CNT_TEX0, 64'd1);
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Advance the shadow walker by one accepted word; queue the report on the last word
  function automatic void census_step(logic [1:0] pth, logic [31:0] prg, logic [63:0] w,
                                      logic [3:0] nb_in, logic lastw);
    logic [3:0]  nb;
    logic        whole;
    logic [31:0] take;
    census_t     rec;
    int          k;
    nb = (nb_in > WORD_BYTES) ? WORD_BYTES : nb_in;
    // a short word not marked last is still parsed as a whole word
    whole = (nb == WORD_BYTES) || !lastw;
    if (!pkt_started) begin
      pkt_path = pth;
      pkt_prog = (pth == 2'd1) ? prg : 32'd0;
      pkt_started = 1'b1;
    end
    tally_add(CNT_BYTES, {60'd0, nb});
    case (walk_phase)
      PH_TAG_LO: begin
        held_lo = w;
        walk_phase = PH_TAG_HI;
      end
      PH_TAG_HI: if (whole) decode_tag(held_lo, w);
      PH_IMAGE: begin
        take = ({28'd0, nb} < image_left) ? {28'd0, nb} : image_left;
        tally_add(CNT_IMAGE, {32'd0, take});
        image_left = (image_left > 32'd8) ? image_left - 32'd8 : 32'd0;
        if (image_left == 0) walk_phase = PH_TAG_LO;
      end
      PH_REGLIST: if (whole) begin
        case (cur_desc())
          DESC_XYZ2, DESC_XYZF2: kick();
          DESC_PRIM: cur_prim = w[2:0];
          default: ;
        endcase
        if (next_slot()) walk_phase = pad_due ? PH_PAD : PH_TAG_LO;
      end
      PH_PAD: begin
        pad_due = 1'b0;
        walk_phase = PH_TAG_LO;
      end
      PH_PACKED_LO: begin
        held_lo = w;
        walk_phase = PH_PACKED_HI;
      end
      PH_PACKED_HI: if (whole) begin
        packed_reg(held_lo, w);
        walk_phase = next_slot() ? PH_TAG_LO : PH_PACKED_LO;
      end
      default: walk_phase = PH_TAG_LO;
    endcase
    if (lastw) begin
      if (tally[CNT_BYTES] >= MIN_REPORT_BYTES) begin
        for (k = 0; k < NUM_CNT; k++) begin
          rec.cpath = pkt_path;
          rec.cprog = pkt_prog;
          rec.cid = 4'(k);
          rec.cval = tally[k][31:0];
          rec.clast = (4'(k) == LAST_CNT_ID);
          append_census(rec);
        end
      end
      clear_packet();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Packet builders
  // ---------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Tag low word with random filler outside the decoded fields
  function automatic logic [63:0] tag_lo(logic [14:0] nloop, logic [1:0] flg, logic [3:0] nreg,
                                         logic pre, logic [2:0] prm);
    logic [63:0] lo;
    lo = rand64();
    lo[14:0] = nloop;
    lo[46] = pre;
    lo[49:47] = prm;
    lo[59:58] = flg;
    lo[63:60] = nreg;
    return lo;
  endfunction

  // Register descriptors biased towards the ones the walker cares about
  function automatic logic [63:0] rand_desc();
    logic [63:0] d;
    int n;
    d = rand64();
    for (n = 0; n < 16; n++) begin
      case ($urandom_range(4))
        0: d[4*n +: 4] = DESC_PRIM;
        1: d[4*n +: 4] = DESC_XYZ2;
        2: d[4*n +: 4] = DESC_XYZF2;
        3: d[4*n +: 4] = DESC_AD;
        default: ;
      endcase
    end
    return d;
  endfunction

  // PACKED high qword: A+D target mostly from the counted set, bit 47 random
  function automatic logic [63:0] rand_qhi();
    logic [63:0] hi;
    hi = rand64();
    case ($urandom_range(7))
      0: hi[7:0] = ADDR_PRIM;
      1: hi[7:0] = ADDR_XYZ2;
      2: hi[7:0] = ADDR_XYZF2;
      3: hi[7:0] = ADDR_TEX0_1;
      4: hi[7:0] = ADDR_TEX0_2;
      5: hi[7:0] = ADDR_BITBLT;
      6: hi[7:0] = ADDR_TRXDIR;
      default: ;
    endcase
    return hi;
  endfunction

  task automatic add_pair(logic [63:0] lo, logic [63:0] hi);
    append_pkt(lo);
    append_pkt(hi);
  endtask

  // Mostly well-formed tag sequences; some cut short, some with junk on the end
  task automatic gen_random_packet();
    int ntags, nl, nr, k, j, cut, npay;
    bit big;
    logic [1:0] flg;
    if ($urandom_range(9) == 0) begin
      append_pkt(rand64());
      return;
    end
    ntags = $urandom_range(1, 3);
    for (k = 0; k < ntags; k++) begin
      big = 1'b0;
      flg = 2'($urandom_range(3));
      nr = $urandom_range(1, 4);
      if ($urandom_range(11) == 0) nr = 16;
      nl = $urandom_range(0, 3);
      if (flg == FLG_PACKED && nr == 16) nl = 0;
      if (flg == FLG_REGLIST && nr == 16 && nl > 1) nl = 1;
      if (flg >= FLG_IMAGE && $urandom_range(19) == 0) begin
        nl = $urandom_range(32767);
        big = 1'b1;
      end
      add_pair(tag_lo(15'(nl), flg, 4'(nr), 1'($urandom_range(1)), 3'($urandom_range(7))),
               rand_desc());
      if (flg == FLG_PACKED) begin
        for (j = 0; j < nl * nr; j++) add_pair(rand64(), rand_qhi());
      end else if (flg == FLG_REGLIST) begin
        for (j = 0; j < nl * nr + ((nl * nr) & 1); j++) append_pkt(rand64());
      end else begin
        npay = big ? ((nl * 2 < 3) ? nl * 2 : 3) : nl * 2;
        for (j = 0; j < npay; j++) append_pkt(rand64());
      end
      if (big) break;
    end
    if ($urandom_range(6) == 0) begin
      cut = $urandom_range(1, pkt_words.size());
      while (pkt_words.size() > cut) pkt_words.pop_back();
    end
    if ($urandom_range(9) == 0) begin
      for (j = 0; j < $urandom_range(1, 2); j++) append_pkt(rand64());
    end
  endtask

  // Move the built packet into the driver queue
  task automatic ship_packet(logic [1:0] pth, logic [31:0] prg, logic [3:0] last_bv, bit ragged);
    gif_word_t it;
    int i, n;
    n = pkt_words.size();
    for (i = 0; i < n; i++) begin
      it.path = pth;
      it.prog = prg;
      it.data = pkt_words[i];
      it.nbytes = WORD_BYTES;
      it.last = (i == n - 1);
      // later words may carry another path/program; the first word's class sticks
      if (ragged && i > 0 && $urandom_range(3) == 0) begin
        it.path = 2'($urandom);
        it.prog = $urandom;
      end
      if (it.last) it.nbytes = last_bv;
      else if (ragged && $urandom_range(5) == 0) it.nbytes = 4'($urandom_range(15));
      append_item(it);
    end
    words_queued += n;
    pkt_words.delete();
  endtask

  task automatic wait_sent();
    while (pending_words.size() != 0 || word_valid) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued words at the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : drive
    gif_word_t nxt;
    logic nv;
    nv = word_valid;
    // previous word went through at the last rising edge
    if (word_valid && words_taken == words_offered) nv = 1'b0;
    if (!nv && !rst && pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
      nxt = pending_words.pop_front();
      path <= nxt.path;
      program_id <= nxt.prog;
      word <= nxt.data;
      bytes_valid <= nxt.nbytes;
      last_word <= nxt.last;
      nv = 1'b1;
      words_offered++;
    end
    word_valid <= nv;
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on every accepted word, checks every accepted counter
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    census_t want;
    if (!rst) begin
      if (word_valid && word_ready) begin
        census_step(path, program_id, word, bytes_valid, last_word);
        words_taken++;
      end
      if (result_valid && result_ready) begin
        if (census_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected counter: path=%0d prog=%h id=%0d count=%0d last=%0b",
                     class_path, class_program, counter_id, count, last_result);
        end else begin
          want = census_q.pop_front();
          if (class_path !== want.cpath || class_program !== want.cprog ||
              counter_id !== want.cid || count !== want.cval || last_result !== want.clast) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"counter mismatch: exp path=%0d prog=%h id=%0d count=%0d last=%0b",
                        " got path=%0d prog=%h id=%0d count=%0d last=%0b"},
                       want.cpath, want.cprog, want.cid, want.cval, want.clast,
                       class_path, class_program, counter_id, count, last_result);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] hi;
    logic [63:0] qlo;
    int ph, start, spin, k;
    logic [3:0] lbv;

    cur_prim = PRIM_UNKNOWN;
    clear_packet();
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: PACKED with PRE, prim write, both vertex kinds, A+D bitblt
    hi = rand64();
    hi[15:0] = {DESC_AD, DESC_XYZF2, DESC_XYZ2, DESC_PRIM};
    add_pair(tag_lo(15'd1, FLG_PACKED, 4'd4, 1'b1, 3'd3), hi);
    qlo = rand64();
    qlo[2:0] = 3'd5;
    add_pair(qlo, rand64());
    hi = rand64();
    hi[47] = 1'b0;
    add_pair(rand64(), hi);
    hi[47] = 1'b1;
    add_pair(rand64(), hi);
    hi = rand64();
    hi[7:0] = ADDR_BITBLT;
    add_pair(rand64(), hi);
    ship_packet(2'd1, 32'hFFFF_FFFF, WORD_BYTES, 1'b0);

    // REGLIST with odd count (pad word), then an image tag cut short mid-payload
    hi = rand64();
    hi[11:0] = {DESC_XYZF2, DESC_XYZ2, DESC_PRIM};
    add_pair(tag_lo(15'd1, FLG_REGLIST, 4'd3, 1'b0, 3'd0), hi);
    qlo = rand64();
    qlo[2:0] = 3'd2;
    append_pkt(qlo);
    for (k = 0; k < 3; k++) append_pkt(rand64());
    add_pair(tag_lo(15'd1, FLG_IMAGE, 4'($urandom), 1'b0, 3'd0), rand64());
    append_pkt(rand64());
    ship_packet(2'd2, 32'h1234_5678, 4'd5, 1'b0);

    // Zero NREG with an empty loop, then A+D trxdir and tex0
    add_pair(tag_lo(15'd0, FLG_PACKED, 4'd0, 1'b0, 3'd0), rand64());
    hi = rand64();
    hi[3:0] = DESC_AD;
    add_pair(tag_lo(15'd2, FLG_PACKED, 4'd1, 1'b0, 3'd0), hi);
    hi = rand64();
    hi[7:0] = ADDR_TRXDIR;
    add_pair(rand64(), hi);
    hi = rand64();
    hi[7:0] = ADDR_TEX0_2;
    add_pair(rand64(), hi);
    ship_packet(2'd3, $urandom, WORD_BYTES, 1'b0);

    // Path zero, empty non-last word, oversized count on the last: under 16 bytes
    append_item(gif_word_t'{2'd0, $urandom, rand64(), 4'd0, 1'b0});
    append_item(gif_word_t'{2'd0, $urandom, rand64(), 4'd15, 1'b1});
    // Exactly 16 bytes, path and program changing on the second word
    append_item(gif_word_t'{2'd1, 32'hA5A5_0001, rand64(), WORD_BYTES, 1'b0});
    append_item(gif_word_t'{2'd3, 32'h5A5A_0002, rand64(), WORD_BYTES, 1'b1});
    wait_sent();

    // Random packets over four idling mixes
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      start = words_queued;
      while (words_queued - start < 10) begin
        gen_random_packet();
        lbv = ($urandom_range(9) < 7) ? WORD_BYTES : 4'($urandom_range(15));
        ship_packet(($urandom_range(7) == 0) ? 2'd0 : 2'($urandom_range(1, 3)), $urandom, lbv,
                    $urandom_range(4) == 0);
      end
      wait_sent();
    end

    // Back-pressure: results held off while short packets keep coming,
    // so the report buffer fills and the input stalls on a last word
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    for (k = 0; k < 8; k++) begin
      add_pair(tag_lo(15'($urandom_range(3)), 2'($urandom), 4'($urandom), 1'($urandom_range(1)),
                      3'($urandom_range(7))), rand_desc());
      ship_packet(2'($urandom_range(1, 3)), $urandom, WORD_BYTES, 1'b0);
    end
    wait_sent();

    // Drain the outstanding reports, then watch for strays
    stall_pct = 22;
    spin = 0;
    while (census_q.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && census_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
